// ===== hdl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the sobel edge magnitude block
// Field widths, configuration codes, pixel and pipeline record types.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FW_W          = 11;
  localparam int FH_W          = 13;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int ROW_W         = 14;
  localparam int N_W           = 24;
  localparam int PIX_W         = 24;
  localparam int CH_W          = 8;
  localparam int NUM_CH        = 3;
  localparam int GRAD_W        = 12;
  localparam int SUM_W         = 22;
  localparam int RAD_W         = 16;
  localparam int REM_W         = 10;
  localparam int SQRT_STEPS    = 8;

  localparam logic [FW_W-1:0]  FW_RESET  = 11'd640;
  localparam logic [FH_W-1:0]  FH_RESET  = 13'd480;
  localparam logic [SUM_W-1:0] SAT_LIMIT = 22'd65280;
  localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0]       col_t;

  typedef struct packed {
    logic                            vld;
    logic                            fend;
    logic [NUM_CH-1:0]               sat;
    logic [NUM_CH-1:0][RAD_W-1:0]    rad;
    logic [NUM_CH-1:0][REM_W-1:0]    rem;
    logic [NUM_CH-1:0][CH_W-1:0]     root;
  } sqrt_t;

endpackage

// ===== hdl/sem_in_if.sv =====
// ----------------------------------------------------------------------------
// sem_in_if: input pixel channel
// Valid/ready channel carrying one pixel or drain item per transfer.
// ----------------------------------------------------------------------------
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, command, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, command, in_red, in_green, in_blue, output ready);
endinterface

// ===== hdl/sem_out_if.sv =====
// ----------------------------------------------------------------------------
// sem_out_if: result channel
// Valid/ready channel carrying one edge magnitude pixel per transfer.
// ----------------------------------------------------------------------------
interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;

  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

// ===== hdl/sobel_edge_magnitude_rgb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 sobel edge magnitude on rgb pixels
// Line stores, a three-column window chain and a square root cell chain.
// ----------------------------------------------------------------------------
// Pixels arrive on pix_i in raster order, one transfer per cycle at most.
// A drain item (command set) enters as a black pixel; after a frame the
// host sends frame_width+1 drain items to flush it. The first
// frame_width+1 items of a frame give no result; every later item gives
// exactly one result on res_o, frame_end marking the last pixel's result.
// An item runs through stages 1 to 3, the square root cell chain and the
// output register. Throughput is one item per cycle unless a result stalls,
// set by the one read and one write port of each line store ram; the
// pipeline advances as a whole. When res_o holds a result that is not
// taken, the whole pipeline freezes and pix_i.ready drops until it is taken.
// Configuration writes (frame_width index 0, frame_height index 1) restart
// the frame and must be made while the block is idle, which the block
// itself does not enforce. Reset restores 640x480 and restarts the frame;
// no clearing pass runs, rows outside the frame are masked by position.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data_i,
  sem_in_if.sink                        pix_i,
  sem_out_if.source                     res_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration and position
  logic [sem_pkg::FW_W-1:0]  fw_q;
  logic [sem_pkg::FH_W-1:0]  fh_q;
  logic [sem_pkg::FW_W-1:0]  col_q, col_d;
  logic [sem_pkg::ROW_W-1:0] row_q, row_d;
  logic [sem_pkg::N_W-1:0]   n_q, n_d;

  logic [sem_pkg::FW_W-1:0]  w_eff;
  logic [sem_pkg::FH_W-1:0]  h_eff;
  logic [sem_pkg::FW_W-1:0]  c0;
  logic                      c_nz;
  logic [sem_pkg::N_W-1:0]   total;
  logic                      emit0, end0;
  logic                      top0, bot0, left0, right0;
  logic [AW-1:0]             addr0;
  logic                      adv, acc, cfg_hit;
  sem_pkg::pix_t             pix0;

  assign adv = !res_o.valid || res_o.ready;
  assign acc = pix_i.valid && adv;
  assign pix_i.ready = adv;
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == sem_pkg::CFG_FRAME_WIDTH) ||
                                (cfg_idx_i == sem_pkg::CFG_FRAME_HEIGHT));

  always_comb begin
    if (fw_q == '0) begin
      w_eff = sem_pkg::FW_W'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = sem_pkg::FW_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_q;
    end
    h_eff = (fh_q == '0) ? sem_pkg::FH_W'(1) : fh_q;
    c0    = (col_q >= w_eff) ? '0 : col_q;
    c_nz  = (c0 != '0);
    total = sem_pkg::N_W'(sem_pkg::N_W'(w_eff) * sem_pkg::N_W'(h_eff))
          + sem_pkg::N_W'(w_eff);
    emit0 = (n_q >= sem_pkg::N_W'(w_eff) + sem_pkg::N_W'(1));
    end0  = emit0 && (n_q >= total);
    // window center is one row up, or two rows up at the row's first column
    top0   = c_nz ? (row_q <= sem_pkg::ROW_W'(1)) : (row_q <= sem_pkg::ROW_W'(2));
    bot0   = c_nz ? (row_q >= sem_pkg::ROW_W'(h_eff))
                  : (row_q >= sem_pkg::ROW_W'(h_eff) + sem_pkg::ROW_W'(1));
    left0  = c_nz ? (c0 == sem_pkg::FW_W'(1)) : (w_eff == sem_pkg::FW_W'(1));
    right0 = !c_nz;
    addr0  = AW'(c0);
    pix0   = (pix_i.command == sem_pkg::CMD_DRAIN) ? '0 :
             {pix_i.in_blue, pix_i.in_green, pix_i.in_red};
  end

  always_comb begin
    n_d   = n_q;
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      n_d   = '0;
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (end0) begin
        n_d   = '0;
        col_d = '0;
        row_d = '0;
      end else begin
        n_d = n_q + sem_pkg::N_W'(1);
        if (c0 + sem_pkg::FW_W'(1) >= w_eff) begin
          col_d = '0;
          row_d = row_q + sem_pkg::ROW_W'(1);
        end else begin
          col_d = c0 + sem_pkg::FW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= sem_pkg::FW_RESET;
      fh_q  <= sem_pkg::FH_RESET;
      n_q   <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      n_q   <= n_d;
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sem_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[sem_pkg::FW_W-1:0];
          sem_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[sem_pkg::FH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // stage 1: line store read data, with bypass of the write in flight
  logic                 s1_vld_q;
  logic                 s1_emit_q, s1_end_q;
  logic [3:0]           s1_mask_q;
  logic [AW-1:0]        s1_addr_q;
  sem_pkg::pix_t        s1_pix_q;
  logic                 s1_byp_q;
  sem_pkg::pix_t        s1_byp_up_q, s1_byp_mid_q;
  sem_pkg::pix_t        up_rdata, mid_rdata;
  sem_pkg::col_t        s1_col;

  assign s1_col[0] = s1_byp_q ? s1_byp_up_q  : up_rdata;
  assign s1_col[1] = s1_byp_q ? s1_byp_mid_q : mid_rdata;
  assign s1_col[2] = s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_emit_q    <= emit0;
      s1_end_q     <= end0;
      s1_mask_q    <= {right0, left0, bot0, top0};
      s1_addr_q    <= addr0;
      s1_pix_q     <= pix0;
      s1_byp_q     <= s1_vld_q && (s1_addr_q == addr0);
      s1_byp_up_q  <= s1_col[1];
      s1_byp_mid_q <= s1_pix_q;
    end
  end

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (adv && s1_vld_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_col[1]),
    .re_i    (adv),
    .raddr_i (addr0),
    .rdata_o (up_rdata)
  );

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (adv && s1_vld_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (adv),
    .raddr_i (addr0),
    .rdata_o (mid_rdata)
  );

  // window chain: cell 2 takes the new column, cell 0 is the oldest
  sem_pkg::col_t tap_col [3];

  sem_tap_cell u_tap2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv && s1_vld_q),
    .col_i (s1_col), .col_o (tap_col[2])
  );
  sem_tap_cell u_tap1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv && s1_vld_q),
    .col_i (tap_col[2]), .col_o (tap_col[1])
  );
  sem_tap_cell u_tap0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv && s1_vld_q),
    .col_i (tap_col[1]), .col_o (tap_col[0])
  );

  // stage 2: masks aligned with the shifted window
  logic       s2_vld_q, s2_end_q;
  logic [3:0] s2_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_end_q  <= s1_end_q;
      s2_mask_q <= s1_mask_q;
    end
  end

  logic signed [sem_pkg::GRAD_W-1:0] gx [sem_pkg::NUM_CH];
  logic signed [sem_pkg::GRAD_W-1:0] gy [sem_pkg::NUM_CH];

  always_comb begin
    logic signed [sem_pkg::GRAD_W-1:0] v [9];
    for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
      for (int k = 0; k < 9; k++) begin
        v[k] = $signed({4'b0000, tap_col[k % 3][k / 3][8*ch +: 8]});
        if ((k / 3 == 0 && s2_mask_q[0]) || (k / 3 == 2 && s2_mask_q[1]) ||
            (k % 3 == 0 && s2_mask_q[2]) || (k % 3 == 2 && s2_mask_q[3])) begin
          v[k] = '0;
        end
      end
      gx[ch] = sem_pkg::GRAD_W'(v[2] - v[0] + 2 * (v[5] - v[3]) + v[8] - v[6]);
      gy[ch] = sem_pkg::GRAD_W'(v[6] - v[0] + 2 * (v[7] - v[1]) + v[8] - v[2]);
    end
  end

  // stage 3: gradients
  logic                              s3_vld_q, s3_end_q;
  logic signed [sem_pkg::GRAD_W-1:0] s3_gx_q [sem_pkg::NUM_CH];
  logic signed [sem_pkg::GRAD_W-1:0] s3_gy_q [sem_pkg::NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_end_q <= s2_end_q;
      s3_gx_q  <= gx;
      s3_gy_q  <= gy;
    end
  end

  // squared magnitude into the first square root record
  sem_pkg::sqrt_t sq_rec [sem_pkg::SQRT_STEPS+1];

  always_comb begin
    logic [sem_pkg::SUM_W-1:0] s;
    sq_rec[0]      = '0;
    sq_rec[0].vld  = s3_vld_q;
    sq_rec[0].fend = s3_end_q;
    for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
      s = sem_pkg::SUM_W'(s3_gx_q[ch]) * sem_pkg::SUM_W'(s3_gx_q[ch])
        + sem_pkg::SUM_W'(s3_gy_q[ch]) * sem_pkg::SUM_W'(s3_gy_q[ch]);
      sq_rec[0].sat[ch] = (s > sem_pkg::SAT_LIMIT);
      sq_rec[0].rad[ch] = s[sem_pkg::RAD_W-1:0];
    end
  end

  for (genvar i = 0; i < sem_pkg::SQRT_STEPS; i++) begin : g_sqrt
    sem_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .rec_i  (sq_rec[i]),
      .rec_o  (sq_rec[i+1])
    );
  end

  // rounding and output register
  sem_pkg::sqrt_t                  fin;
  logic [sem_pkg::CH_W-1:0]        mag [sem_pkg::NUM_CH];
  logic                            out_vld_q, out_end_q;
  logic [sem_pkg::CH_W-1:0]        out_mag_q [sem_pkg::NUM_CH];

  assign fin = sq_rec[sem_pkg::SQRT_STEPS];

  always_comb begin
    logic [sem_pkg::CH_W:0] m;
    for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
      m = {1'b0, fin.root[ch]} +
          (sem_pkg::CH_W+1)'(fin.rem[ch] > sem_pkg::REM_W'(fin.root[ch]));
      if (fin.sat[ch] || m[sem_pkg::CH_W]) begin
        mag[ch] = sem_pkg::CH_MAX;
      end else begin
        mag[ch] = m[sem_pkg::CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_end_q <= fin.fend;
      out_mag_q <= mag;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.edge_red   = out_mag_q[0];
  assign res_o.edge_green = out_mag_q[1];
  assign res_o.edge_blue  = out_mag_q[2];
  assign res_o.frame_end  = out_end_q;

`ifndef SYNTHESIS
  // the item count never passes the frame's last item
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= total)
    else $error("item count beyond frame end");

  // a frame end transfer restarts the position
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && end0) |=> (n_q == '0 && col_q == '0 && row_q == '0))
    else $error("frame end did not restart position");

  // a frame end item always yields a result into the pipeline
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_end_q) |-> s1_emit_q)
    else $error("frame end without result");
`endif

endmodule

// ===== hdl/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram: generic single-write, single-read ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sem_tap_cell.sv =====
// ----------------------------------------------------------------------------
// sem_tap_cell: one column of the 3x3 window
// Holds three pixels and takes the column of its right neighbor on shift.
// ----------------------------------------------------------------------------
module sem_tap_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  sem_pkg::col_t     col_i,
  output sem_pkg::col_t     col_o
);

  sem_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hdl/sem_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sem_sqrt_cell: one step of the digit-by-digit square root
// Resolves one root bit per channel and hands the record to the next cell.
// ----------------------------------------------------------------------------
module sem_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  sem_pkg::sqrt_t  rec_i,
  output sem_pkg::sqrt_t  rec_o
);

  sem_pkg::sqrt_t rec_d;
  logic           vld_q;
  sem_pkg::sqrt_t rec_q;

  always_comb begin
    logic [sem_pkg::REM_W+1:0] rem_x;
    logic [sem_pkg::REM_W+1:0] trial;
    rec_d = rec_i;
    for (int ch = 0; ch < sem_pkg::NUM_CH; ch++) begin
      rem_x = {rec_i.rem[ch], rec_i.rad[ch][sem_pkg::RAD_W-1 -: 2]};
      trial = (sem_pkg::REM_W+2)'({rec_i.root[ch], 2'b01});
      rec_d.rad[ch] = {rec_i.rad[ch][sem_pkg::RAD_W-3:0], 2'b00};
      if (rem_x >= trial) begin
        rec_d.rem[ch]  = sem_pkg::REM_W'(rem_x - trial);
        rec_d.root[ch] = {rec_i.root[ch][sem_pkg::CH_W-2:0], 1'b1};
      end else begin
        rec_d.rem[ch]  = sem_pkg::REM_W'(rem_x);
        rec_d.root[ch] = {rec_i.root[ch][sem_pkg::CH_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= rec_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec_q <= rec_d;
    end
  end

  always_comb begin
    rec_o     = rec_q;
    rec_o.vld = vld_q;
  end

endmodule

// ===== tb/sem_checker.sv =====
// ----------------------------------------------------------------------------
// sem_checker: result predictor and scoreboard for sobel_edge_magnitude_rgb
// Watches the configuration port and both channels, predicts every result
// from its own copy of the line stores and window, and compares in order.
// ----------------------------------------------------------------------------
module sem_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data_i,
  sem_in_if                             pix,
  sem_out_if                            res,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct {
    logic [sem_pkg::CH_W-1:0] red;
    logic [sem_pkg::CH_W-1:0] green;
    logic [sem_pkg::CH_W-1:0] blue;
    logic                     fend;
  } edge_pix_t;

  logic [sem_pkg::FW_W-1:0] width_reg;
  logic [sem_pkg::FH_W-1:0] height_reg;
  sem_pkg::pix_t            upper_row[sem_pkg::MAX_WIDTH_DEF];
  sem_pkg::pix_t            middle_row[sem_pkg::MAX_WIDTH_DEF];
  sem_pkg::pix_t            taps[9];
  int unsigned              col_pos;
  int unsigned              row_pos;
  int unsigned              taken;
  edge_pix_t                edge_q[$];

  const int kern_x[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  const int kern_y[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  function automatic logic [sem_pkg::CH_W-1:0] nearest_root(int unsigned s);
    int unsigned m;
    if (s > 65280) return 8'd255;
    m = 0;
    for (int b = 128; b > 0; b = b >> 1) begin
      if ((m | b) * (m | b) <= s) m = m | b;
    end
    if (s - m * m > m) m++;
    if (m > 255) m = 255;
    return m[sem_pkg::CH_W-1:0];
  endfunction

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    taken   = 0;
  endtask

  task automatic take_item(logic cmd, logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
    sem_pkg::pix_t px;
    sem_pkg::pix_t column[3];
    int unsigned   w, h, c, n;
    int            cr, cc, gx, gy, v, tr, tc;
    logic [7:0]    mag[3];
    edge_pix_t     e;
    w  = (width_reg == 0) ? 1 : ((width_reg > sem_pkg::MAX_WIDTH_DEF) ?
                                 sem_pkg::MAX_WIDTH_DEF : width_reg);
    h  = (height_reg == 0) ? 1 : height_reg;
    px = (cmd == sem_pkg::CMD_DRAIN) ? '0 : {blu, grn, red};
    c  = (col_pos >= w) ? 0 : col_pos;
    n  = taken;
    column[0] = upper_row[c];
    column[1] = middle_row[c];
    column[2] = px;
    upper_row[c]  = column[1];
    middle_row[c] = px;
    for (int r = 0; r < 3; r++) begin
      taps[r*3]   = taps[r*3+1];
      taps[r*3+1] = taps[r*3+2];
      taps[r*3+2] = column[r];
    end
    // center: one row, one column back; at column 0, last column two rows up
    if (c >= 1) begin
      cr = int'(row_pos) - 1;
      cc = int'(c) - 1;
    end else begin
      cr = int'(row_pos) - 2;
      cc = int'(w) - 1;
    end
    taken = n + 1;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos = c + 1;
    end
    if (n < w + 1) return;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int k = 0; k < 9; k++) begin
        tr = k / 3;
        tc = k % 3;
        if (tr == 0 && cr <= 0) continue;
        if (tr == 2 && cr >= int'(h) - 1) continue;
        if (tc == 0 && cc <= 0) continue;
        if (tc == 2 && cc >= int'(w) - 1) continue;
        v  = (taps[k] >> (8 * ch)) & 8'hFF;
        gx += kern_x[k] * v;
        gy += kern_y[k] * v;
      end
      mag[ch] = nearest_root(gx * gx + gy * gy);
    end
    e.red   = mag[0];
    e.green = mag[1];
    e.blue  = mag[2];
    e.fend  = (n >= w * h + w);
    if (e.fend) restart_frame();
    edge_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = sem_pkg::FW_RESET;
      height_reg = sem_pkg::FH_RESET;
      for (int i = 0; i < sem_pkg::MAX_WIDTH_DEF; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) taps[i] = '0;
      restart_frame();
      edge_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == sem_pkg::CFG_FRAME_WIDTH) begin
          width_reg = cfg_data_i[sem_pkg::FW_W-1:0];
          restart_frame();
        end else if (cfg_idx_i == sem_pkg::CFG_FRAME_HEIGHT) begin
          height_reg = cfg_data_i[sem_pkg::FH_W-1:0];
          restart_frame();
        end
      end
      if (res.valid && res.ready) begin
        if (edge_q.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0b", $time,
                   res.edge_red, res.edge_green, res.edge_blue, res.frame_end);
          fail_count_o++;
        end else begin
          edge_pix_t e;
          e = edge_q.pop_front();
          if (e.red !== res.edge_red || e.green !== res.edge_green ||
              e.blue !== res.edge_blue || e.fend !== res.frame_end) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d end=%0b",
                     $time, e.red, e.green, e.blue, e.fend,
                     " actual r=%0d g=%0d b=%0d end=%0b",
                     res.edge_red, res.edge_green, res.edge_blue, res.frame_end);
            fail_count_o++;
          end
        end
      end
      if (pix.valid && pix.ready)
        take_item(pix.command, pix.in_red, pix.in_green, pix.in_blue);
      pending_o = edge_q.size();
    end
  end

  final begin
    if (edge_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, edge_q.size());
  end
endmodule

// ===== tb/sobel_edge_magnitude_rgb_test.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_test: stimulus and verdict for the sobel block
// Runs directed frames at the size extremes, then random frames of random
// size with drains inside frames, pixels in place of drains, idling phases
// and a long result stall; checking is done by sem_checker.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_test;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 20;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [sem_pkg::CFG_W-1:0]     cfg_data;
  int                            fail_count;
  int                            pending;
  int                            sender_idle_pct;
  int                            recv_stall_pct;
  bit                            hold_req;
  int                            idle_cycles;
  int                            items_sent;

  sem_in_if  pix_ch();
  sem_out_if res_ch();

  sobel_edge_magnitude_rgb uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_ch),
    .res_o      (res_ch)
  );

  sem_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix          (pix_ch),
    .res          (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        res_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sobel_edge_magnitude_rgb verification failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] chan_value();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(logic cmd, logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.command  <= cmd;
    pix_ch.in_red   <= red;
    pix_ch.in_green <= grn;
    pix_ch.in_blue  <= blu;
    do @(posedge clk_i); while (!pix_ch.ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // items without results may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(sem_pkg::cfg_idx_e idx, logic [sem_pkg::CFG_W-1:0] data);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    write_reg(sem_pkg::CFG_FRAME_WIDTH, sem_pkg::CFG_W'(w));
    write_reg(sem_pkg::CFG_FRAME_HEIGHT, sem_pkg::CFG_W'(h));
  endtask

  // npix pixels then ndrain flush items; noisy mixes drains into the frame
  // and pixels into the flush
  task automatic send_stream(int npix, int ndrain, bit noisy);
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_item(sem_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_item(sem_pkg::CMD_PIXEL, chan_value(), chan_value(), chan_value());
    end
    for (int i = 0; i < ndrain; i++) begin
      if (noisy && $urandom_range(0, 7) == 0)
        send_item(sem_pkg::CMD_PIXEL, chan_value(), chan_value(), chan_value());
      else
        send_item(sem_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  initial begin
    int w, h, phase;
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= sem_pkg::CFG_FRAME_WIDTH;
    cfg_data        <= '0;
    pix_ch.valid    <= 1'b0;
    pix_ch.command  <= sem_pkg::CMD_PIXEL;
    pix_ch.in_red   <= '0;
    pix_ch.in_green <= '0;
    pix_ch.in_blue  <= '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    items_sent      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size, partial frame, then restarted by a write
    send_stream(8, 0, 0);
    // 3x3 checkerboard of extremes with a drain inside the frame
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(sem_pkg::CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      else if (i % 2) send_item(sem_pkg::CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
      else send_item(sem_pkg::CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
    end
    send_stream(0, 4, 0);
    // unlisted indexes leave the size alone
    write_reg(sem_pkg::cfg_idx_e'(2), sem_pkg::CFG_W'($urandom));
    write_reg(sem_pkg::cfg_idx_e'(3), sem_pkg::CFG_W'($urandom));
    send_stream(9, 4, 1);
    // zero width and height act as one
    set_size(0, 0);
    send_stream(1, 2, 0);
    send_item(sem_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_stream(0, 2, 0);
    set_size(1, 5);
    send_stream(5, 2, 0);
    // width beyond the line store acts as its depth, cut short by the next write
    set_size(2047, 1);
    send_stream(1024, 40, 0);
    // tallest frame, cut short by the next write
    set_size(4, 8191);
    send_stream(40, 0, 1);

    phase = 0;
    while (items_sent < 1800 || phase < 4) begin
      set_idling(phase);
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(13, 64);
        h = 1;
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
      set_size(w, h);
      if (phase == 1) begin
        set_size(40, 6);
        w = 40;
        h = 6;
        hold_req = 1'b1;
      end
      for (int f = (phase == 1) ? 1 : $urandom_range(1, 3); f > 0; f--)
        send_stream(w * h, w + 1, $urandom_range(0, 2) != 0);
      phase++;
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("sobel_edge_magnitude_rgb verification clean");
    end else begin
      $display("sobel_edge_magnitude_rgb verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/sem_pkg.sv
hdl/sem_in_if.sv
hdl/sem_out_if.sv
hdl/sem_ram.sv
hdl/sem_tap_cell.sv
hdl/sem_sqrt_cell.sv
hdl/sobel_edge_magnitude_rgb.sv
tb/sem_checker.sv
tb/sobel_edge_magnitude_rgb_test.sv
